// ===== sv/ctmf_pkg.sv =====
// Shared types and constants for the color threshold / 3x3 morphology filter.
// No dependencies; every other file imports this package.
package ctmf_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int PIX_W         = 8;
    localparam int LW_W          = 11;
    localparam int CNT_W         = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 11;
    localparam int NUM_WIN_CELLS = 2;
    localparam int MIN_WIDTH     = 3;

    localparam logic [1:0] ROW_SAT = 2'd2;

    localparam logic [PIX_W-1:0] RST_BLUE_LOW   = 8'd20;
    localparam logic [PIX_W-1:0] RST_BLUE_HIGH  = 8'd120;
    localparam logic [PIX_W-1:0] RST_GREEN_LOW  = 8'd200;
    localparam logic [PIX_W-1:0] RST_GREEN_HIGH = 8'd255;
    localparam logic [PIX_W-1:0] RST_RED_LOW    = 8'd130;
    localparam logic [PIX_W-1:0] RST_RED_HIGH   = 8'd255;
    localparam logic [LW_W-1:0]  RST_LINE_WIDTH = 11'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLUE_LOW,
        REG_BLUE_HIGH,
        REG_GREEN_LOW,
        REG_GREEN_HIGH,
        REG_RED_LOW,
        REG_RED_HIGH,
        REG_LINE_WIDTH,
        REG_MORPH_MODE
    } cfg_reg_e;

    typedef enum logic {
        MORPH_ERODE  = 1'b0,
        MORPH_DILATE = 1'b1
    } morph_mode_e;

    typedef struct packed {
        logic [PIX_W-1:0] blue_low;
        logic [PIX_W-1:0] blue_high;
        logic [PIX_W-1:0] green_low;
        logic [PIX_W-1:0] green_high;
        logic [PIX_W-1:0] red_low;
        logic [PIX_W-1:0] red_high;
        logic [CNT_W-1:0] eff_width;
        morph_mode_e      mode;
    } cfg_t;

    // one window column: [2] current row, [1] one row back, [0] two rows back
    typedef logic [2:0] win_col_t;

endpackage

// ===== sv/ctmf_pix_if.sv =====
// Pixel input channel: valid/ready plus BGR channels and frame start flag.
// Depends on ctmf_pkg.
interface ctmf_pix_if;
    import ctmf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             frame_start;

    modport source(output valid, blue, green, red, frame_start, input ready);
    modport sink(input valid, blue, green, red, frame_start, output ready);
endinterface

// ===== sv/ctmf_res_if.sv =====
// Result channel: valid/ready plus mask and filtered window fields.
// Depends on ctmf_pkg.
interface ctmf_res_if;
    import ctmf_pkg::*;

    logic             valid;
    logic             ready;
    logic             mask_bit;
    logic             filtered_bit;
    logic             filtered_valid;
    logic [COL_W-1:0] centre_column;

    modport source(output valid, mask_bit, filtered_bit, filtered_valid, centre_column,
                   input ready);
    modport sink(input valid, mask_bit, filtered_bit, filtered_valid, centre_column,
                 output ready);
endinterface

// ===== sv/ctmf_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on ctmf_pkg.
interface ctmf_cfg_if;
    import ctmf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/color_threshold_morph_filter.sv =====
// Top level: color threshold mask plus 3x3 erosion/dilation over a raster stream.
// Depends on ctmf_pkg, the channel interfaces, ctmf_cfg_regs, ctmf_line_store,
// ctmf_win_cell.
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+-----------
//  pix     | in  | blue, green, red, frame_start                    | valid/ready
//  res     | out | mask_bit, filtered_bit, filtered_valid, centre_column | valid/ready
//  cfg     | in  | index, data                                      | valid/ready
//
// One pixel per clock sustained while res is ready; a pixel is registered into
// the read stage at its transfer edge and then into the output register, which
// drives its result.
// The line store has one read and one write port; a read of the address being
// written in the same cycle is served from a one-entry bypass.
// Reset clears control, sets config defaults; line store is undefined until written.
// A stalled result holds; one more pixel is taken into the read stage meanwhile.
module color_threshold_morph_filter (
    input  logic      clk,
    input  logic      rst_n,
    ctmf_pix_if.sink  pix,
    ctmf_res_if.source res,
    ctmf_cfg_if.sink  cfg
);
    import ctmf_pkg::*;

    cfg_t cfg_q;

    ctmf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // ---------------- input stage: column/row tracking and threshold
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [1:0]       row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] cur_col;
    logic [1:0]       cur_row;
    logic [CNT_W-1:0] col_inc;
    logic             cur_mask;
    logic             cur_fvalid;
    logic             accept;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_mask_reg;
    logic             s1_fvalid_reg;
    logic             byp_reg;
    logic [1:0]       byp_data_reg;
    logic             s1_move;

    logic             out_valid_reg;
    logic             out_mask_reg;
    logic             out_fbit_reg;
    logic             out_fvalid_reg;
    logic [COL_W-1:0] out_col_reg;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign pix.ready = !s1_valid_reg || s1_move;
    assign accept    = pix.valid && pix.ready;

    always_comb
    begin
        cur_col  = pix.frame_start ? '0 : col_cnt_reg;
        cur_row  = pix.frame_start ? '0 : row_cnt_reg;
        col_inc  = CNT_W'(cur_col) + CNT_W'(1);
        cur_mask = (pix.blue  >= cfg_q.blue_low)  && (pix.blue  <= cfg_q.blue_high) &&
                   (pix.green >= cfg_q.green_low) && (pix.green <= cfg_q.green_high) &&
                   (pix.red   >= cfg_q.red_low)   && (pix.red   <= cfg_q.red_high);
        cur_fvalid = (cur_row == ROW_SAT) && (cur_col >= COL_W'(2));
        if (col_inc >= cfg_q.eff_width)
        begin
            col_cnt_next = '0;
            row_cnt_next = (cur_row == ROW_SAT) ? cur_row : cur_row + 2'd1;
        end
        else
        begin
            col_cnt_next = col_inc[COL_W-1:0];
            row_cnt_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------- line store
    logic [1:0] ls_rd_data;
    logic [1:0] ls_word;
    logic [1:0] ls_wr_data;

    assign ls_word    = byp_reg ? byp_data_reg : ls_rd_data;
    assign ls_wr_data = {ls_word[0], s1_mask_reg};

    ctmf_line_store u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (ls_rd_data),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (ls_wr_data)
    );

    // ---------------- read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                // same column written by the item leaving this cycle
                byp_reg      <= s1_move && (s1_col_reg == cur_col);
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
                byp_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= cur_col;
            s1_mask_reg   <= cur_mask;
            s1_fvalid_reg <= cur_fvalid;
            byp_data_reg  <= ls_wr_data;
        end
    end

    // ---------------- window: incoming column plus a chain of column cells
    win_col_t win_col [NUM_WIN_CELLS+1];
    logic [3*(NUM_WIN_CELLS+1)-1:0] win_bits;
    logic fbit;

    assign win_col[0] = {s1_mask_reg, ls_word[0], ls_word[1]};

    for (genvar i = 0; i < NUM_WIN_CELLS; i++)
    begin : g_cells
        ctmf_win_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (s1_move),
            .col_in   (win_col[i]),
            .col_out  (win_col[i+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i <= NUM_WIN_CELLS; i++)
            win_bits[3*i +: 3] = win_col[i];
        case (cfg_q.mode)
            MORPH_DILATE: fbit = |win_bits;
            MORPH_ERODE:  fbit = &win_bits;
            default:      fbit = 1'b0;
        endcase
    end

    // ---------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_mask_reg   <= s1_mask_reg;
            out_fvalid_reg <= s1_fvalid_reg;
            out_fbit_reg   <= s1_fvalid_reg && fbit;
            out_col_reg    <= s1_fvalid_reg ? s1_col_reg - COL_W'(1) : '0;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.mask_bit       = out_mask_reg;
    assign res.filtered_bit   = out_fbit_reg;
    assign res.filtered_valid = out_fvalid_reg;
    assign res.centre_column  = out_col_reg;

    // ---------------- checks
    a_invalid_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.filtered_valid |-> !res.filtered_bit && res.centre_column == '0)
        else $error("invalid window result carries nonzero fields");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pix.ready |-> s1_valid_reg && out_valid_reg && !res.ready)
        else $error("input stalled without a full pipeline");

    a_bypass_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> s1_valid_reg)
        else $error("line store bypass set with empty read stage");

    a_valid_has_margin: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_fvalid_reg |-> s1_col_reg >= COL_W'(2))
        else $error("window marked valid too close to row start");

endmodule

// ===== sv/ctmf_cfg_regs.sv =====
// Configuration register bank; also clamps line_width into the usable range.
// Depends on ctmf_pkg and ctmf_cfg_if.
module ctmf_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    ctmf_cfg_if.sink        cfg,
    output ctmf_pkg::cfg_t  cfg_q
);
    import ctmf_pkg::*;

    logic [PIX_W-1:0] blue_low_reg, blue_high_reg;
    logic [PIX_W-1:0] green_low_reg, green_high_reg;
    logic [PIX_W-1:0] red_low_reg, red_high_reg;
    logic [LW_W-1:0]  line_width_reg;
    morph_mode_e      mode_reg;
    logic [CNT_W-1:0] width_ext;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_low_reg   <= RST_BLUE_LOW;
            blue_high_reg  <= RST_BLUE_HIGH;
            green_low_reg  <= RST_GREEN_LOW;
            green_high_reg <= RST_GREEN_HIGH;
            red_low_reg    <= RST_RED_LOW;
            red_high_reg   <= RST_RED_HIGH;
            line_width_reg <= RST_LINE_WIDTH;
            mode_reg       <= MORPH_ERODE;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_e'(cfg.index))
                REG_BLUE_LOW:   blue_low_reg   <= cfg.data[PIX_W-1:0];
                REG_BLUE_HIGH:  blue_high_reg  <= cfg.data[PIX_W-1:0];
                REG_GREEN_LOW:  green_low_reg  <= cfg.data[PIX_W-1:0];
                REG_GREEN_HIGH: green_high_reg <= cfg.data[PIX_W-1:0];
                REG_RED_LOW:    red_low_reg    <= cfg.data[PIX_W-1:0];
                REG_RED_HIGH:   red_high_reg   <= cfg.data[PIX_W-1:0];
                REG_LINE_WIDTH: line_width_reg <= cfg.data[LW_W-1:0];
                REG_MORPH_MODE: mode_reg       <= morph_mode_e'(cfg.data[0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        width_ext = CNT_W'(line_width_reg);
        if (width_ext < CNT_W'(MIN_WIDTH))
            width_ext = CNT_W'(MIN_WIDTH);
        else if (width_ext > CNT_W'(MAX_WIDTH))
            width_ext = CNT_W'(MAX_WIDTH);
    end

    assign cfg_q.blue_low   = blue_low_reg;
    assign cfg_q.blue_high  = blue_high_reg;
    assign cfg_q.green_low  = green_low_reg;
    assign cfg_q.green_high = green_high_reg;
    assign cfg_q.red_low    = red_low_reg;
    assign cfg_q.red_high   = red_high_reg;
    assign cfg_q.eff_width  = width_ext;
    assign cfg_q.mode       = mode_reg;

endmodule

// ===== sv/ctmf_line_store.sv =====
// Two line stores of mask bits packed as one 2-bit wide memory:
// bit 1 holds the row two back, bit 0 the row one back. Depends on ctmf_pkg.
module ctmf_line_store (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [ctmf_pkg::COL_W-1:0] rd_addr,
    output logic [1:0]                rd_data,
    input  logic                      wr_en,
    input  logic [ctmf_pkg::COL_W-1:0] wr_addr,
    input  logic [1:0]                wr_data
);
    import ctmf_pkg::*;

    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ctmf_win_cell.sv =====
// One column of the 3x3 window; cells chain to shift the window by a column.
// Depends on ctmf_pkg.
module ctmf_win_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  ctmf_pkg::win_col_t  col_in,
    output ctmf_pkg::win_col_t  col_out
);
    import ctmf_pkg::*;

    win_col_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else if (shift_en)
            col_reg <= col_in;
    end

    assign col_out = col_reg;

endmodule
